// File: rtl/core/c3lb_pkg.sv
// ----------------------------------------------------------------------------
// c3lb_pkg
// Shared constants and types for the 3x3 line-buffered convolution stream.
// ----------------------------------------------------------------------------
package c3lb_pkg;

    localparam int LINE_WIDTH   = 256;
    localparam int DATA_BITS    = 16;
    localparam int FRAC_BITS    = 8;
    localparam int KSIZE        = 3;
    localparam int COEF_BITS    = 16;

    localparam int FRAME_ROWS_W = 16;
    localparam int FRAME_COLS_W = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = KSIZE * COEF_BITS;

    localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = FRAME_ROWS_W'(128);
    localparam logic [FRAME_COLS_W-1:0] FRAME_COLS_RST = FRAME_COLS_W'(128);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS = 3'd0,
        CFG_FRAME_COLS = 3'd1,
        CFG_KERNEL_TOP = 3'd2,
        CFG_KERNEL_MID = 3'd3,
        CFG_KERNEL_BOT = 3'd4
    } t_cfg_idx;

    typedef logic [KSIZE-1:0][COEF_BITS-1:0] t_coef_vec;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

// File: rtl/core/c3lb_pix_if.sv
// ----------------------------------------------------------------------------
// c3lb_pix_if
// Valid/ready channel carrying one signed input pixel per transaction.
// ----------------------------------------------------------------------------
interface c3lb_pix_if #(
    parameter int DATA_BITS = c3lb_pkg::DATA_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// File: rtl/core/c3lb_res_if.sv
// ----------------------------------------------------------------------------
// c3lb_res_if
// Valid/ready channel carrying one filtered pixel and its frame end flag.
// ----------------------------------------------------------------------------
interface c3lb_res_if #(
    parameter int DATA_BITS = c3lb_pkg::DATA_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] filtered;
    logic                 frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

// File: rtl/core/c3lb_line_store.sv
// ----------------------------------------------------------------------------
// c3lb_line_store
// Two line stores held as one memory word per column, registered read.
// ----------------------------------------------------------------------------
module c3lb_line_store #(
    parameter int LINE_WIDTH = c3lb_pkg::LINE_WIDTH,
    parameter int DATA_BITS  = c3lb_pkg::DATA_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(LINE_WIDTH)-1:0] i_rd_addr,
    output logic [2*DATA_BITS-1:0]        o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(LINE_WIDTH)-1:0] i_wr_addr,
    input  logic [2*DATA_BITS-1:0]        i_wr_data
);

    logic [2*DATA_BITS-1:0] r_mem [LINE_WIDTH];
    logic [2*DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/c3lb_cell.sv
// ----------------------------------------------------------------------------
// c3lb_cell
// One window column: three taps, three products and their column sum.
// ----------------------------------------------------------------------------
module c3lb_cell #(
    parameter int DATA_BITS = c3lb_pkg::DATA_BITS,
    parameter int FRAC_BITS = c3lb_pkg::FRAC_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  c3lb_pkg::t_cell_ctrl                         i_ctrl,
    input  logic [c3lb_pkg::KSIZE-1:0][DATA_BITS-1:0]    i_col,
    input  c3lb_pkg::t_coef_vec                          i_coef,
    output logic [c3lb_pkg::KSIZE-1:0][DATA_BITS-1:0]    o_col,
    output logic [DATA_BITS-1:0]                         o_psum
);

    localparam int PROD_W = DATA_BITS + c3lb_pkg::COEF_BITS;

    logic [c3lb_pkg::KSIZE-1:0][DATA_BITS-1:0] r_taps;
    logic [DATA_BITS-1:0]                      r_psum;
    logic [DATA_BITS-1:0]                      n_psum;
    logic signed [PROD_W-1:0]                  prod [c3lb_pkg::KSIZE];
    logic signed [PROD_W-1:0]                  prod_sh [c3lb_pkg::KSIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= '0;
        end else if (i_ctrl.shift) begin
            r_taps <= i_col;
        end
    end

    // Each product is floored to the pixel format by an arithmetic shift.
    always_comb begin
        n_psum = '0;
        for (int r = 0; r < c3lb_pkg::KSIZE; r++) begin
            prod[r]    = $signed(r_taps[r]) * $signed(i_coef[r]);
            prod_sh[r] = prod[r] >>> FRAC_BITS;
            n_psum     = n_psum + prod_sh[r][DATA_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_psum <= n_psum;
        end
    end

    assign o_col  = r_taps;
    assign o_psum = r_psum;

endmodule

// File: rtl/core/conv3x3_line_buffer_stream_top.sv
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_stream_top
// Streaming 3x3 correlation over a raster of signed fixed-point pixels.
//
//   Channel   Dir  Transaction contents
//   i_pix     in   pixel
//   o_res     out  filtered, frame_end
//   i_cfg_*   in   register index and write data, no handshake
//
// One pixel is taken per cycle unless back-pressure from o_res stalls the pipeline.
// A result passes the registered line store read, the window update, the
// product stage in the column cells and the output register.
// Reset is synchronous and clears counters, window and pipeline valids; the
// line store is not cleared and needs no clearing pass.
// Back-pressure moves stage by stage, so empty stages still take new pixels.
// ----------------------------------------------------------------------------
module conv3x3_line_buffer_stream_top #(
    parameter int LINE_WIDTH = c3lb_pkg::LINE_WIDTH,
    parameter int DATA_BITS  = c3lb_pkg::DATA_BITS,
    parameter int FRAC_BITS  = c3lb_pkg::FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    c3lb_pix_if.sink                          i_pix,
    c3lb_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [c3lb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [c3lb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int KSIZE  = c3lb_pkg::KSIZE;
    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int ROW_W  = c3lb_pkg::FRAME_ROWS_W;
    localparam int FC_W   = c3lb_pkg::FRAME_COLS_W;
    localparam int LWC_W  = $clog2(LINE_WIDTH + 1);
    localparam int CNT_W  = (LWC_W > FC_W) ? LWC_W : FC_W;
    localparam int CDW    = c3lb_pkg::CFG_DATA_W;
    localparam logic [CDW-1:0] KERNEL_MID_RST =
        CDW'(1) << (c3lb_pkg::COEF_BITS + FRAC_BITS);

    // Configuration registers.
    logic [ROW_W-1:0] r_frame_rows;
    logic [FC_W-1:0]  r_frame_cols;
    logic [CDW-1:0]   r_kernel [KSIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= c3lb_pkg::FRAME_ROWS_RST;
            r_frame_cols <= c3lb_pkg::FRAME_COLS_RST;
            r_kernel[0]  <= '0;
            r_kernel[1]  <= KERNEL_MID_RST;
            r_kernel[2]  <= '0;
        end else if (i_cfg_we) begin
            case (c3lb_pkg::t_cfg_idx'(i_cfg_idx))
                c3lb_pkg::CFG_FRAME_ROWS: r_frame_rows <= i_cfg_data[ROW_W-1:0];
                c3lb_pkg::CFG_FRAME_COLS: r_frame_cols <= i_cfg_data[FC_W-1:0];
                c3lb_pkg::CFG_KERNEL_TOP: r_kernel[0]  <= i_cfg_data;
                c3lb_pkg::CFG_KERNEL_MID: r_kernel[1]  <= i_cfg_data;
                c3lb_pkg::CFG_KERNEL_BOT: r_kernel[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake.
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic adv1, adv2, adv3;
    logic accept;

    assign rdy4   = !r_v4 || o_res.ready;
    assign adv3   = r_v3 && rdy4;
    assign rdy3   = !r_v3 || rdy4;
    assign adv2   = r_v2 && rdy3;
    assign rdy2   = !r_v2 || rdy3;
    assign adv1   = r_v1 && rdy2;
    assign rdy1   = !r_v1 || rdy2;
    assign accept = i_pix.valid && rdy1;
    assign i_pix.ready = rdy1;

    // Raster counters.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CNT_W-1:0] ecols;
    logic [CNT_W-1:0] ecols_m1;
    logic             last_col;
    logic             last_row;
    logic             border;

    always_comb begin
        if ((r_frame_cols == '0) || (CNT_W'(r_frame_cols) > CNT_W'(LINE_WIDTH))) begin
            ecols = CNT_W'(LINE_WIDTH);
        end else begin
            ecols = CNT_W'(r_frame_cols);
        end
        ecols_m1 = ecols - CNT_W'(1);
        last_col = CNT_W'(r_col) >= ecols_m1;
        last_row = r_row >= (r_frame_rows - ROW_W'(1));
        border   = (r_row < ROW_W'(2)) || (r_col < COL_W'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Stage 1: line store word arrives; the word written by the previous
    // pixel is forwarded when both pixels fall on the same column.
    logic [DATA_BITS-1:0]   r_px1;
    logic [COL_W-1:0]       r_addr1;
    logic                   r_hit1;
    logic [2*DATA_BITS-1:0] r_fwd1;
    logic                   r_border1, r_last1;
    logic [2*DATA_BITS-1:0] rd_data;
    logic [2*DATA_BITS-1:0] word1;
    logic [DATA_BITS-1:0]   older1, newer1;

    assign word1  = r_hit1 ? r_fwd1 : rd_data;
    assign older1 = word1[2*DATA_BITS-1:DATA_BITS];
    assign newer1 = word1[DATA_BITS-1:0];

    c3lb_line_store #(
        .LINE_WIDTH (LINE_WIDTH),
        .DATA_BITS  (DATA_BITS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (adv1),
        .i_wr_addr (r_addr1),
        .i_wr_data ({newer1, r_px1})
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1     <= i_pix.pixel;
            r_addr1   <= r_col;
            r_hit1    <= adv1 && (r_addr1 == r_col);
            r_fwd1    <= {newer1, r_px1};
            r_border1 <= border;
            r_last1   <= last_col && last_row;
        end
    end

    // Stages 2 and 3: the window shifts in as the pixel enters stage 2; the
    // column cells register their partial sums on the way to stage 3.
    logic r_border2, r_last2, r_border3, r_last3;
    c3lb_pkg::t_cell_ctrl                cell_ctrl;
    logic [KSIZE-1:0][DATA_BITS-1:0]     new_col;
    logic [KSIZE-1:0][DATA_BITS-1:0]     cell_col  [KSIZE];
    logic [DATA_BITS-1:0]                cell_psum [KSIZE];
    c3lb_pkg::t_coef_vec                 cell_coef [KSIZE];

    assign cell_ctrl.shift = adv1;
    assign cell_ctrl.load  = adv2;
    assign new_col[0] = older1;
    assign new_col[1] = newer1;
    assign new_col[2] = r_px1;

    for (genvar c = 0; c < KSIZE; c++) begin : g_cell
        for (genvar r = 0; r < KSIZE; r++) begin : g_coef
            assign cell_coef[c][r] =
                r_kernel[r][c*c3lb_pkg::COEF_BITS +: c3lb_pkg::COEF_BITS];
        end
        c3lb_cell #(
            .DATA_BITS (DATA_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_col   ((c == KSIZE - 1) ? new_col : cell_col[(c + 1) % KSIZE]),
            .i_coef  (cell_coef[c]),
            .o_col   (cell_col[c]),
            .o_psum  (cell_psum[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_border2 <= r_border1;
            r_last2   <= r_last1;
        end
        if (adv2) begin
            r_border3 <= r_border2;
            r_last3   <= r_last2;
        end
    end

    // Stage 4: output register.
    logic [DATA_BITS-1:0] r_filt;
    logic                 r_last4;
    logic [DATA_BITS-1:0] n_filt;

    always_comb begin
        n_filt = '0;
        for (int c = 0; c < KSIZE; c++) begin
            n_filt = n_filt + cell_psum[c];
        end
        if (r_border3) begin
            n_filt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_filt  <= n_filt;
            r_last4 <= r_last3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept;
            if (rdy2) r_v2 <= adv1;
            if (rdy3) r_v3 <= adv2;
            if (rdy4) r_v4 <= adv3;
        end
    end

    assign o_res.valid     = r_v4;
    assign o_res.filtered  = r_filt;
    assign o_res.frame_end = r_last4;

endmodule

// File: rtl/core/c3lb_checker.sv
// ----------------------------------------------------------------------------
// c3lb_checker
// Port-level checks for the convolution stream, bound to the top level.
// ----------------------------------------------------------------------------
module c3lb_checker #(
    parameter int DATA_BITS = c3lb_pkg::DATA_BITS
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_pix_ready,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [DATA_BITS-1:0] i_res_filtered,
    input logic                 i_res_frame_end
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_filtered) && $stable(i_res_frame_end))
        else $error("Stalled result transaction changed or vanished.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("Result valid directly after reset.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_pix_ready)
        else $error("Input stalled although no result is waiting.");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ready |-> i_pix_ready)
        else $error("Input stalled although the result side is ready.");

endmodule

bind conv3x3_line_buffer_stream_top c3lb_checker #(
    .DATA_BITS (DATA_BITS)
) u_c3lb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pix_ready     (i_pix.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_filtered  (o_res.filtered),
    .i_res_frame_end (o_res.frame_end)
);

// File: tb/conv3x3_line_buffer_stream_checker.sv
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_stream_checker
// Watches the pixel, result and register write ports of the 3x3 correlation
// stream. It keeps its own copy of the line stores, window, counters and
// registers, and predicts the filtered value and frame end flag of every
// accepted pixel. Each result transaction is compared with the oldest
// prediction, and mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module conv3x3_line_buffer_stream_checker
    import c3lb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pix_valid,
    input  logic                    i_pix_ready,
    input  logic [DATA_BITS-1:0]    i_pix_data,
    input  logic                    i_res_valid,
    input  logic                    i_res_ready,
    input  logic [DATA_BITS-1:0]    i_res_filtered,
    input  logic                    i_res_frame_end,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_BITS-1:0] filtered;
        logic                 frame_end;
    } t_filtered_pixel;

    t_filtered_pixel         filtered_q[$];

    logic [FRAME_ROWS_W-1:0] rows_reg;
    logic [FRAME_COLS_W-1:0] cols_reg;
    t_coef_vec               kernel_reg [KSIZE];

    logic [DATA_BITS-1:0]    older_mem [LINE_WIDTH];
    logic [DATA_BITS-1:0]    newer_mem [LINE_WIDTH];
    logic [DATA_BITS-1:0]    taps [KSIZE][KSIZE];
    logic [15:0]             row_cnt;
    logic [7:0]              col_cnt;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic convolve_pixel(input logic [DATA_BITS-1:0] px,
                                  output t_filtered_pixel res);
        int                   ecols;
        int                   erows;
        int                   r;
        int                   c;
        logic signed [31:0]   prod;
        logic [DATA_BITS-1:0] acc;
        logic                 last_col;
        logic                 last_row;
        ecols = (cols_reg == 0 || cols_reg > LINE_WIDTH) ? LINE_WIDTH : int'(cols_reg);
        erows = (rows_reg == 0) ? 65536 : int'(rows_reg);
        for (r = 0; r < KSIZE; r++) begin
            for (c = 0; c < KSIZE - 1; c++) begin
                taps[r][c] = taps[r][c+1];
            end
        end
        taps[0][KSIZE-1] = older_mem[col_cnt];
        taps[1][KSIZE-1] = newer_mem[col_cnt];
        taps[2][KSIZE-1] = px;
        older_mem[col_cnt] = newer_mem[col_cnt];
        newer_mem[col_cnt] = px;
        acc = '0;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            for (r = 0; r < KSIZE; r++) begin
                for (c = 0; c < KSIZE; c++) begin
                    prod = $signed(taps[r][c]) * $signed(kernel_reg[r][c]);
                    acc  = acc + prod[FRAC_BITS +: DATA_BITS];
                end
            end
        end
        last_col      = int'(col_cnt) >= ecols - 1;
        last_row      = int'(row_cnt) >= erows - 1;
        res.filtered  = acc;
        res.frame_end = last_col && last_row;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_filtered_pixel want;
        int              i;
        if (!i_rst_n) begin
            filtered_q.delete();
            o_fail_count  = 0;
            rows_reg      = FRAME_ROWS_RST;
            cols_reg      = FRAME_COLS_RST;
            kernel_reg[0] = '0;
            kernel_reg[1] = '0;
            kernel_reg[1][1] = COEF_BITS'(1 << FRAC_BITS);
            kernel_reg[2] = '0;
            for (i = 0; i < LINE_WIDTH; i++) begin
                older_mem[i] = '0;
                newer_mem[i] = '0;
            end
            for (i = 0; i < KSIZE * KSIZE; i++) begin
                taps[i / KSIZE][i % KSIZE] = '0;
            end
            row_cnt = '0;
            col_cnt = '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_ROWS: rows_reg = i_cfg_data[FRAME_ROWS_W-1:0];
                    CFG_FRAME_COLS: cols_reg = i_cfg_data[FRAME_COLS_W-1:0];
                    CFG_KERNEL_TOP: kernel_reg[0] = i_cfg_data;
                    CFG_KERNEL_MID: kernel_reg[1] = i_cfg_data;
                    CFG_KERNEL_BOT: kernel_reg[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                convolve_pixel(i_pix_data, want);
                filtered_q.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: filtered=%h frame_end=%b",
                                              i_res_filtered, i_res_frame_end));
                end else begin
                    want = filtered_q.pop_front();
                    if (i_res_filtered !== want.filtered) begin
                        report_mismatch($sformatf("filtered %h, predicted %h",
                                                  i_res_filtered, want.filtered));
                    end
                    if (i_res_frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end %b, predicted %b",
                                                  i_res_frame_end, want.frame_end));
                    end
                end
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

// File: tb/conv3x3_line_buffer_stream_top_tb.sv
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_stream_top_tb
// Drives the 3x3 correlation stream with bursts of pixels under several frame
// sizes and kernels, with random back-pressure on the result channel, and
// reports the verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module conv3x3_line_buffer_stream_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3lb_pkg::*;

    localparam int ITEM_TARGET  = 1750;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_NS     = 1_000_000;

    typedef enum int {
        ALWAYS_READY,
        HALF_READY,
        MOSTLY_READY,
        MOSTLY_STALLED
    } t_stall_mode;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int sent;
    int burst_left;
    int hold_requests;
    int holds_done;

    logic [DATA_BITS-1:0] extreme_pixels [9] = '{
        16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
        16'h0100, 16'h7F00, 16'h8001, 16'h00FF
    };

    c3lb_pix_if pix_ch ();
    c3lb_res_if res_ch ();

    conv3x3_line_buffer_stream_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    conv3x3_line_buffer_stream_checker conv_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_pix_valid     (pix_ch.valid),
        .i_pix_ready     (pix_ch.ready),
        .i_pix_data      (pix_ch.pixel),
        .i_res_valid     (res_ch.valid),
        .i_res_ready     (res_ch.ready),
        .i_res_filtered  (res_ch.filtered),
        .i_res_frame_end (res_ch.frame_end),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("conv3x3_line_buffer_stream_top_tb: FAIL");
        $finish;
    end

    function automatic logic [DATA_BITS-1:0] random_pixel();
        case ($urandom_range(0, 3))
            0, 1: return DATA_BITS'($urandom);
            2: return DATA_BITS'(int'($urandom_range(0, 2047)) - 1024);
            default: return extreme_pixels[$urandom_range(0, 8)];
        endcase
    endfunction

    function automatic t_coef_vec random_kernel();
        t_coef_vec k;
        int        c;
        for (c = 0; c < KSIZE; c++) begin
            case ($urandom_range(0, 3))
                0: k[c] = COEF_BITS'($urandom);
                1: k[c] = COEF_BITS'(int'($urandom_range(0, 1023)) - 512);
                2: k[c] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: k[c] = $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
            endcase
        end
        return k;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic configure(input logic [FRAME_ROWS_W-1:0] rows,
                             input logic [FRAME_COLS_W-1:0] cols,
                             input t_coef_vec top, input t_coef_vec mid,
                             input t_coef_vec bot);
        write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_FRAME_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_KERNEL_TOP, top);
        write_reg(CFG_KERNEL_MID, mid);
        write_reg(CFG_KERNEL_BOT, bot);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [DATA_BITS-1:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        burst_left--;
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        mode         = ALWAYS_READY;
        mode_left    = 0;
        hold_left    = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    ALWAYS_READY:   res_ch.ready <= 1'b1;
                    HALF_READY:     res_ch.ready <= 1'($urandom_range(0, 1));
                    MOSTLY_READY:   res_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:        res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        logic [FRAME_ROWS_W-1:0] rows_v;
        logic [FRAME_COLS_W-1:0] cols_v;
        int                      ec;
        int                      er;
        int                      n;
        int                      phase;
        rst_n         <= 1'b0;
        pix_ch.valid  <= 1'b0;
        pix_ch.pixel  <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_FRAME_ROWS;
        cfg_data      <= '0;
        sent          = 0;
        burst_left    = 0;
        hold_requests = 0;
        holds_done    = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Two full-width rows write every line store entry before any window
        // position inside the border can read one.
        write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(2));
        write_reg(CFG_FRAME_COLS, CFG_DATA_W'(LINE_WIDTH));
        cfg_we <= 1'b0;
        repeat (2 * LINE_WIDTH) send_pixel(random_pixel());
        wait_idle();

        write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(3));
        write_reg(CFG_FRAME_COLS, CFG_DATA_W'(3));
        cfg_we <= 1'b0;
        foreach (extreme_pixels[i]) send_pixel(extreme_pixels[i]);
        wait_idle();

        configure(FRAME_ROWS_W'(3), FRAME_COLS_W'(3), {3{16'h7FFF}}, {3{16'h8000}},
                  {16'h8000, 16'h0100, 16'hFFFF});
        foreach (extreme_pixels[i]) send_pixel(extreme_pixels[i]);
        wait_idle();

        // Zero rows means a full-height frame; shrinking it afterwards leaves
        // the row counter past the end, which must close the frame at once.
        configure(FRAME_ROWS_W'(0), FRAME_COLS_W'(1), random_kernel(), random_kernel(),
                  random_kernel());
        repeat (4) send_pixel(random_pixel());
        wait_idle();
        configure(FRAME_ROWS_W'(2), FRAME_COLS_W'(1), random_kernel(), random_kernel(),
                  random_kernel());
        repeat (3) send_pixel(random_pixel());
        wait_idle();

        phase = 0;
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: cols_v = FRAME_COLS_W'(0);
                    1: cols_v = FRAME_COLS_W'(LINE_WIDTH);
                    2: cols_v = FRAME_COLS_W'(300);
                    default: cols_v = FRAME_COLS_W'(511);
                endcase
            end else begin
                cols_v = FRAME_COLS_W'($urandom_range(1, 12));
            end
            if ($urandom_range(0, 9) == 0) begin
                rows_v = $urandom_range(0, 1) ? 16'd0 : 16'd65535;
            end else begin
                rows_v = FRAME_ROWS_W'($urandom_range(1, 6));
            end
            configure(rows_v, cols_v, random_kernel(), random_kernel(), random_kernel());
            ec = (cols_v == 0 || cols_v > LINE_WIDTH) ? LINE_WIDTH : int'(cols_v);
            er = (rows_v == 0) ? 65536 : int'(rows_v);
            if (ec * er <= 200) begin
                n = ec * er * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, ec * er);
            end else begin
                n = $urandom_range(20, (ec > 16) ? 600 : 150);
            end
            if (phase == 0) begin
                if (n < 60) n = 60;
                hold_requests++;
            end
            if (n > ITEM_TARGET - sent) n = ITEM_TARGET - sent;
            repeat (n) send_pixel(random_pixel());
            wait_idle();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("conv3x3_line_buffer_stream_top_tb: PASS");
        end else begin
            $display("conv3x3_line_buffer_stream_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/c3lb_pkg.sv
rtl/core/c3lb_pix_if.sv
rtl/core/c3lb_res_if.sv
rtl/core/c3lb_line_store.sv
rtl/core/c3lb_cell.sv
rtl/core/conv3x3_line_buffer_stream_top.sv
rtl/core/c3lb_checker.sv
tb/conv3x3_line_buffer_stream_checker.sv
tb/conv3x3_line_buffer_stream_top_tb.sv
